// File: rtl/plir_pkg.sv
// shared types and codes of the positional list
package plir_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 8;
    localparam int COUNT_W = 5;

    typedef enum logic
    {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } plir_cmd_t;

    // operation broadcast to every cell of the chain
    typedef struct packed
    {
        logic                      ins;
        logic                      rem;
        logic [POS_W-1:0]          slot;
        logic signed [VALUE_W-1:0] value;
    } plir_op_t;

endpackage

// File: rtl/plir_if.sv
// valid/ready channel interfaces for requests and results
interface plir_req_if;
    import plir_pkg::*;

    logic                      valid;
    logic                      ready;
    plir_cmd_t                 cmd;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;

    modport source (output valid, output cmd, output value, output position, input ready);
    modport sink (input valid, input cmd, input value, input position, output ready);
endinterface

interface plir_res_if;
    import plir_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      rejected;
    logic signed [VALUE_W-1:0] head_value;
    logic                      head_valid;
    logic [COUNT_W-1:0]        entry_count;

    modport source (output valid, output rejected, output head_value, output head_valid,
                    output entry_count, input ready);
    modport sink (input valid, input rejected, input head_value, input head_valid,
                  input entry_count, output ready);
endinterface

// File: rtl/plir_cell.sv
// one storage cell of the list chain
module plir_cell #(
    parameter int IDX = 0
) (
    input  logic                               clk,
    input  plir_pkg::plir_op_t                 op,
    input  logic signed [plir_pkg::VALUE_W-1:0] left_data,
    input  logic signed [plir_pkg::VALUE_W-1:0] right_data,
    output logic signed [plir_pkg::VALUE_W-1:0] data
);
    import plir_pkg::*;

    localparam logic [POS_W-1:0] MY_SLOT = POS_W'(IDX);

    logic signed [VALUE_W-1:0] data_reg;
    logic signed [VALUE_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (op.ins)
        begin
            if (MY_SLOT > op.slot)
            begin
                data_next = left_data;
            end
            else if (MY_SLOT == op.slot)
            begin
                data_next = op.value;
            end
        end
        else if (op.rem)
        begin
            if (MY_SLOT >= op.slot)
            begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// File: rtl/positional_list_insert_remove.sv
// positional list top level: cell chain, length counter and result register
//
// usage
//   request channel: cmd (insert or remove), value, 1-based position
//   result channel: rejected flag, head value, head valid, entry count
//   every request transaction yields exactly one result transaction
//   insert at position p shifts entries p..count up one cell, remove at p
//   shifts entries above p down one cell; the whole chain moves together
// the result is registered and appears in the cycle after the request is taken
// throughput: one transaction per cycle while results are taken; each cell
//   reads only its neighbors and the broadcast operation
// stall: while a result waits and the receiver holds ready low, request
//   ready drops; a result being taken frees the slot in the same cycle
// reset: count and result valid clear; cell contents are undefined until
//   written and are never shown while the list is empty
// bad positions, or an insert into a full list, change nothing and set
//   rejected; entry_count shows the count modulo 32
module positional_list_insert_remove #(
    parameter int CAPACITY = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    plir_req_if.sink   request,
    plir_res_if.source result
);
    import plir_pkg::*;

    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = 10;

    // length of the list
    logic [LEN_W-1:0] length_reg;
    logic [LEN_W-1:0] length_next;

    // result register
    logic                      res_valid_reg;
    logic                      res_rejected_reg;
    logic signed [VALUE_W-1:0] res_head_reg;
    logic                      res_head_valid_reg;
    logic [COUNT_W-1:0]        res_count_reg;

    logic                      take;
    logic [CMP_W-1:0]          pos_ext;
    logic [CMP_W-1:0]          len_ext;
    logic [CMP_W-1:0]          len_next_ext;
    logic                      ins_ok;
    logic                      rem_ok;
    plir_op_t                  op;
    logic signed [VALUE_W-1:0] cell_data [CAPACITY];
    logic signed [VALUE_W-1:0] head_next;

    // a new request enters when the result slot is free or being emptied
    assign request.ready = !res_valid_reg || result.ready;
    assign take          = request.valid && request.ready;

    assign pos_ext = CMP_W'(request.position);
    assign len_ext = CMP_W'(length_reg);

    // range checks on the 1-based position
    assign ins_ok = (request.cmd == CMD_INSERT) && (pos_ext != '0)
                    && (pos_ext <= len_ext + CMP_W'(1))
                    && (len_ext < CMP_W'(CAPACITY));
    assign rem_ok = (request.cmd == CMD_REMOVE) && (pos_ext != '0)
                    && (pos_ext <= len_ext);

    // broadcast the shift to the chain, slot is zero-based
    always_comb
    begin
        op.ins   = take && ins_ok;
        op.rem   = take && rem_ok;
        op.slot  = request.position - POS_W'(1);
        op.value = request.value;
    end

    always_comb
    begin
        length_next = length_reg;
        if (op.ins)
        begin
            length_next = length_reg + LEN_W'(1);
        end
        else if (op.rem)
        begin
            length_next = length_reg - LEN_W'(1);
        end
    end

    // head after the operation, taken from the cells around the front
    always_comb
    begin
        head_next = cell_data[0];
        if (op.ins && op.slot == '0)
        begin
            head_next = request.value;
        end
        else if (op.rem && op.slot == '0)
        begin
            head_next = cell_data[1];
        end
    end

    assign len_next_ext = CMP_W'(length_next);

    // row of cells; the ends feed themselves since those inputs never matter
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [VALUE_W-1:0] left_d;
        logic signed [VALUE_W-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = cell_data[i];
        end
        else
        begin : g_left
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_d = cell_data[i];
        end
        else
        begin : g_right
            assign right_d = cell_data[i+1];
        end

        plir_cell #(
            .IDX (i)
        ) u_cell (
            .clk        (clk),
            .op         (op),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            length_reg <= length_next;
            if (take)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_rejected_reg   <= !(ins_ok || rem_ok);
            res_head_valid_reg <= (length_next != '0);
            res_head_reg       <= (length_next != '0) ? head_next : '0;
            res_count_reg      <= len_next_ext[COUNT_W-1:0];
        end
    end

    assign result.valid       = res_valid_reg;
    assign result.rejected    = res_rejected_reg;
    assign result.head_value  = res_head_reg;
    assign result.head_valid  = res_head_valid_reg;
    assign result.entry_count = res_count_reg;

endmodule

// File: rtl/plir_checker.sv
// port-level checks of the positional list, bound to the top level
module plir_checker #(
    parameter int CAPACITY = 16
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                req_ready,
    input logic                                res_valid,
    input logic                                res_ready,
    input logic                                res_rejected,
    input logic                                res_head_valid,
    input logic signed [plir_pkg::VALUE_W-1:0] res_head_value,
    input logic [plir_pkg::COUNT_W-1:0]        res_count
);
    import plir_pkg::*;

    logic [COUNT_W-1:0] last_count_reg;
    logic               res_take;

    assign res_take = res_valid && res_ready;

    // count of the last delivered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_count_reg <= '0;
        end
        else if (res_take)
        begin
            last_count_reg <= res_count;
        end
    end

    // a stalled result holds its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_count)
            && $stable(res_head_value) && $stable(res_rejected))
        else $error("result changed while stalled");

    // requests back off exactly when a result is stuck
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready == (!res_valid || res_ready))
        else $error("request ready does not follow the result slot");

    // a rejected transaction leaves the count alone
    a_reject_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_take && res_rejected |-> res_count == last_count_reg)
        else $error("rejected transaction changed the count");

    // an accepted transaction moves the count by one
    a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_take && !res_rejected |->
            (res_count == last_count_reg + COUNT_W'(1))
            || (res_count == last_count_reg - COUNT_W'(1)))
        else $error("count moved by more than one");

    // head valid agrees with the count and an empty list shows zero
    a_head: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (CAPACITY < 32) |->
            (res_head_valid == (res_count != '0))
            && (res_head_valid || res_head_value == '0))
        else $error("head fields disagree with the count");

endmodule

bind positional_list_insert_remove plir_checker #(
    .CAPACITY (CAPACITY)
) u_plir_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_ready      (request.ready),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .res_rejected   (result.rejected),
    .res_head_valid (result.head_valid),
    .res_head_value (result.head_value),
    .res_count      (result.entry_count)
);
